// ----- hw/rtl/spta_pkg.sv -----
package spta_pkg;

  // Field widths of the point and angle transactions.
  localparam int unsigned CoordWidth  = 32;
  localparam int unsigned AngleBits   = 16;
  localparam int unsigned DiffWidth   = CoordWidth + 1;

  // The largest normalized magnitude sits in [2^NormTop, 2^(NormTop+1)).
  localparam int unsigned NormWidth   = 56;
  localparam int unsigned NormTop     = NormWidth - 1;
  localparam int unsigned ShiftWidth  = $clog2(NormWidth);
  localparam int unsigned ChunkWidth  = 8;
  localparam int unsigned NumChunks   = NormWidth / ChunkWidth;

  // CORDIC datapath; wide enough for two gain factors on a normalized vector.
  localparam int unsigned DataWidth   = 62;
  localparam int unsigned AccWidth    = 32;
  localparam int unsigned CordicSteps = 28;

  // Gain compensation splits the operand in two halves.
  localparam int unsigned HalfNorm    = NormWidth / 2;
  localparam int unsigned GainWidth   = 31;
  localparam int unsigned ProdWidth   = HalfNorm + GainWidth;
  localparam logic [GainWidth-1:0] GainQ30 = 31'd1768195363;

  // Pipeline depth: seven front stages, two CORDIC runs, one middle and one final stage.
  localparam int unsigned PreStages   = 7;
  localparam int unsigned NumStages   = PreStages + CordicSteps + 1 + CordicSteps + 1;

  // Angles in units of 2^-32 turn.
  localparam logic [30:0] QuarterTurn = 31'h4000_0000;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;
  localparam logic [AngleBits-1:0] QuarterUnits = AngleBits'(1 << (AngleBits - 2));

  localparam logic [31:0] AtanTurns [CordicSteps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5
  };

  // Register indexes on the configuration port.
  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegCenterZ = 2'd2;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic signed [CoordWidth-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic        [AngleBits-1:0] azimuth;
    logic signed [AngleBits-1:0] elevation;
  } angles_t;

  // Per-point status that travels with the data.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic zero;
    logic x_zero;
    logic y_zero;
    logic z_zero;
  } flags_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] x;
    logic signed [DataWidth-1:0] y;
    logic signed [AccWidth-1:0]  acc;
  } cordic_t;

  typedef struct packed {
    cordic_t                c;
    logic [DataWidth-1:0]   gain_y;
    flags_t                 f;
  } c1_stage_t;

  typedef struct packed {
    cordic_t                c;
    logic [AngleBits-1:0]   azim;
    flags_t                 f;
  } c2_stage_t;

  // Leading zeros of one byte, zero when it is empty.
  function automatic logic [2:0] chunk_lz(input logic [ChunkWidth-1:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int b = 0; b < ChunkWidth; b++) begin
      if (v[b]) begin
        n = 3'(ChunkWidth - 1 - b);
      end
    end
    return n;
  endfunction

  // One vectoring step with floor shifts by a fixed amount.
  function automatic cordic_t cordic_step(input cordic_t c, input int unsigned i);
    cordic_t r;
    logic signed [DataWidth-1:0] xs;
    logic signed [DataWidth-1:0] ys;
    xs = c.y >>> i;
    ys = c.x >>> i;
    if (!c.y[DataWidth-1]) begin
      r.x   = c.x + xs;
      r.y   = c.y - ys;
      r.acc = c.acc + $signed(AtanTurns[i]);
    end else begin
      r.x   = c.x - xs;
      r.y   = c.y + ys;
      r.acc = c.acc - $signed(AtanTurns[i]);
    end
    return r;
  endfunction

  // Limits an accumulated angle to the first quadrant.
  function automatic logic [30:0] clamp_quarter(input logic signed [AccWidth-1:0] acc);
    logic [30:0] a;
    if (acc[AccWidth-1]) begin
      a = '0;
    end else if (acc > $signed({1'b0, QuarterTurn})) begin
      a = QuarterTurn;
    end else begin
      a = acc[30:0];
    end
    return a;
  endfunction

  // Rounds a turn value half up to angle units, modulo one turn.
  function automatic logic [AngleBits-1:0] turn_to_units(input logic [31:0] t);
    logic [32:0] sum;
    sum = {1'b0, t} + (33'd1 << (31 - AngleBits));
    return sum[31 -: AngleBits];
  endfunction

endpackage

// ----- hw/rtl/sphere_point_to_angles_unit.sv -----
// Throughput: one point per cycle while the skid register is empty; each of the two
// 28-step CORDIC chains has one register stage per step, and the front end normalizes
// and scales in seven stages.
// A two-entry output (last stage plus skid register) keeps in_ready_o registered.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears the centre registers.
module sphere_point_to_angles_unit import spta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  point_t      in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output angles_t     out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [CoordWidth-1:0] center_x_q, center_y_q, center_z_q;
  logic                         en;
  logic [NumStages-1:0]         vld_q;
  logic                         skid_full_q, skid_full_d;
  angles_t                      skid_q, out_q;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegCenterX: center_x_q <= pwdata[CoordWidth-1:0];
        RegCenterY: center_y_q <= pwdata[CoordWidth-1:0];
        RegCenterZ: center_z_q <= pwdata[CoordWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegCenterX: prdata = 32'(center_x_q);
      RegCenterY: prdata = 32'(center_y_q);
      RegCenterZ: prdata = 32'(center_z_q);
      default:    prdata = '0;
    endcase
  end

  // The whole pipeline moves while the skid register is empty.
  assign en         = ~skid_full_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // Stage 1: offsets from the centre at full precision.
  logic signed [DiffWidth-1:0] s1_d_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_d_q[0] <= {in_data_i.point_x[CoordWidth-1], in_data_i.point_x}
                 - {center_x_q[CoordWidth-1], center_x_q};
      s1_d_q[1] <= {in_data_i.point_y[CoordWidth-1], in_data_i.point_y}
                 - {center_y_q[CoordWidth-1], center_y_q};
      s1_d_q[2] <= {in_data_i.point_z[CoordWidth-1], in_data_i.point_z}
                 - {center_z_q[CoordWidth-1], center_z_q};
    end
  end

  // Stage 2: magnitudes and signs.
  logic [NormWidth-1:0] s2_a_q [3];
  flags_t               s2_f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_a_q[k] <= {{(NormWidth - DiffWidth){1'b0}},
                      (s1_d_q[k][DiffWidth-1] ? -s1_d_q[k] : s1_d_q[k])};
      end
      s2_f_q <= '{neg_x: s1_d_q[0][DiffWidth-1], neg_y: s1_d_q[1][DiffWidth-1],
                  neg_z: s1_d_q[2][DiffWidth-1], default: 1'b0};
    end
  end

  // Stage 3: leading zeros of the largest magnitude, one byte at a time.
  logic [NormWidth-1:0] or_all;
  logic [NumChunks-1:0] s3_nz_q;
  logic [2:0]           s3_lz_q [NumChunks];
  logic [NormWidth-1:0] s3_a_q [3];
  flags_t               s3_f_q;

  assign or_all = s2_a_q[0] | s2_a_q[1] | s2_a_q[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NumChunks; c++) begin
        s3_nz_q[c] <= |or_all[NormTop - ChunkWidth * c -: ChunkWidth];
        s3_lz_q[c] <= chunk_lz(or_all[NormTop - ChunkWidth * c -: ChunkWidth]);
      end
      s3_a_q <= s2_a_q;
      s3_f_q <= s2_f_q;
    end
  end

  // Stage 4: the first nonzero byte sets the normalizing shift.
  logic [ShiftWidth-1:0] shift_amt;
  flags_t                f4;
  logic [ShiftWidth-1:0] s4_shift_q;
  logic [NormWidth-1:0]  s4_a_q [3];
  flags_t                s4_f_q;

  always_comb begin
    shift_amt = '0;
    for (int c = NumChunks - 1; c >= 0; c--) begin
      if (s3_nz_q[c]) begin
        shift_amt = ShiftWidth'(ChunkWidth * c) + ShiftWidth'(s3_lz_q[c]);
      end
    end
    f4      = s3_f_q;
    f4.zero = ~|s3_nz_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_shift_q <= shift_amt;
      s4_a_q     <= s3_a_q;
      s4_f_q     <= f4;
    end
  end

  // Stage 5: normalizing shift of all three magnitudes.
  logic [NormWidth-1:0] s5_n_q [3];
  flags_t               s5_f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s5_n_q[k] <= s4_a_q[k] << s4_shift_q;
      end
      s5_f_q <= s4_f_q;
    end
  end

  // Stage 6: partial products of the vertical magnitude with the CORDIC gain.
  flags_t               f6;
  logic [ProdWidth-1:0] s6_ph_q, s6_pl_q;
  logic [NormWidth-1:0] s6_nx_q, s6_nz_q;
  flags_t               s6_f_q;

  always_comb begin
    f6        = s5_f_q;
    f6.x_zero = ~|s5_n_q[0];
    f6.y_zero = ~|s5_n_q[1];
    f6.z_zero = ~|s5_n_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_ph_q <= ProdWidth'(s5_n_q[1][NormWidth-1:HalfNorm]) * ProdWidth'(GainQ30);
      s6_pl_q <= ProdWidth'(s5_n_q[1][HalfNorm-1:0]) * ProdWidth'(GainQ30);
      s6_nx_q <= s5_n_q[0];
      s6_nz_q <= s5_n_q[2];
      s6_f_q  <= f6;
    end
  end

  // Stage 7: combine the partial products and load the first CORDIC.
  logic [ProdWidth:0]   low_sum;
  logic [ProdWidth-3:0] gain_y;
  c1_stage_t            s7_q;

  always_comb begin
    low_sum = (ProdWidth + 1)'({s6_ph_q[1:0], {HalfNorm{1'b0}}})
            + (ProdWidth + 1)'(s6_pl_q);
    gain_y  = s6_ph_q[ProdWidth-1:2] + (ProdWidth - 2)'(low_sum >> (HalfNorm + 2));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q.c.x    <= DataWidth'(s6_nx_q);
      s7_q.c.y    <= DataWidth'(s6_nz_q);
      s7_q.c.acc  <= '0;
      s7_q.gain_y <= DataWidth'(gain_y);
      s7_q.f      <= s6_f_q;
    end
  end

  // First CORDIC: azimuth angle and horizontal length, one step per stage.
  c1_stage_t c1_q [CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_c1
    c1_stage_t cin;
    if (i == 0) begin : g_first
      assign cin = s7_q;
    end else begin : g_next
      assign cin = c1_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        c1_q[i].c      <= cordic_step(cin.c, i);
        c1_q[i].gain_y <= cin.gain_y;
        c1_q[i].f      <= cin.f;
      end
    end
  end

  // Middle stage: azimuth to its quadrant; load the second CORDIC.
  c1_stage_t   c1_last;
  logic [30:0] az_first;
  logic [31:0] az_turn;
  c2_stage_t   s8_q;

  assign c1_last = c1_q[CordicSteps-1];

  always_comb begin
    if (c1_last.f.z_zero) begin
      az_first = '0;
    end else if (c1_last.f.x_zero) begin
      az_first = QuarterTurn;
    end else begin
      az_first = clamp_quarter(c1_last.c.acc);
    end
    if (!c1_last.f.neg_x && !c1_last.f.neg_z) begin
      az_turn = {1'b0, az_first};
    end else if (c1_last.f.neg_x && !c1_last.f.neg_z) begin
      az_turn = HalfTurn - {1'b0, az_first};
    end else if (c1_last.f.neg_x) begin
      az_turn = HalfTurn + {1'b0, az_first};
    end else begin
      az_turn = 32'd0 - {1'b0, az_first};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q.c.x   <= c1_last.c.x;
      s8_q.c.y   <= c1_last.gain_y;
      s8_q.c.acc <= '0;
      s8_q.azim  <= turn_to_units(az_turn);
      s8_q.f     <= c1_last.f;
    end
  end

  // Second CORDIC: elevation against the horizontal length.
  c2_stage_t c2_q [CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_c2
    c2_stage_t cin;
    if (i == 0) begin : g_first
      assign cin = s8_q;
    end else begin : g_next
      assign cin = c2_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        c2_q[i].c    <= cordic_step(cin.c, i);
        c2_q[i].azim <= cin.azim;
        c2_q[i].f    <= cin.f;
      end
    end
  end

  // Final stage: special cases and the sign of the elevation.
  c2_stage_t            c2_last;
  logic [AngleBits-1:0] elev_mag, elev;

  assign c2_last = c2_q[CordicSteps-1];

  always_comb begin
    if (c2_last.f.zero || c2_last.f.y_zero) begin
      elev_mag = '0;
    end else if (c2_last.f.x_zero && c2_last.f.z_zero) begin
      elev_mag = QuarterUnits;
    end else begin
      elev_mag = turn_to_units({1'b0, clamp_quarter(c2_last.c.acc)});
    end
    elev = c2_last.f.neg_y ? -elev_mag : elev_mag;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.azimuth   <= c2_last.azim;
      out_q.elevation <= elev;
    end
  end

  // Skid register catches the last stage when the consumer stalls.
  always_comb begin
    if (skid_full_q) begin
      skid_full_d = ~out_ready_i;
    end else begin
      skid_full_d = vld_q[NumStages-1] & ~out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else begin
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      skid_q <= out_q;
    end
  end

  assign out_valid_o = skid_full_q | vld_q[NumStages-1];
  assign out_data_o  = skid_full_q ? skid_q : out_q;

`ifndef SYNTHESIS
  // An accepted point enters the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted point did not enter the pipeline");

  // A waiting result in the skid register is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_full_q && !out_ready_i) |=> (skid_full_q && $stable(skid_q)))
    else $error("skid register lost a waiting result");

  // The pipeline is frozen while the skid register is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |=> $stable(vld_q))
    else $error("pipeline moved while the skid register was full");

  // Elevation stays within a quarter turn either way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.elevation) <= $signed(QuarterUnits) &&
                     $signed(out_data_o.elevation) >= -$signed(QuarterUnits)))
    else $error("elevation out of range");
`endif

endmodule

// ----- tb/tb_sphere_point_to_angles_unit.sv -----
`timescale 1ns / 100ps

module tb_sphere_point_to_angles_unit;
  import spta_pkg::*;

  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned DrainCycles  = 75;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomPoints = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  point_t      in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  angles_t     out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Centre values as the block should currently hold them.
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic signed [31:0] centre_z;

  point_t  point_queue[$];
  angles_t angles_queue[$];

  int max_gap;
  int max_stall;
  int gap_cnt;
  int stall_cnt;
  int points_sent;
  int angles_checked;
  int error_cnt;
  int cycle_cnt;

  sphere_point_to_angles_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Vectoring CORDIC on x >= 0; returns the angle in 2^-32 turn, limited to a quarter.
  function automatic logic [30:0] cordic_vector(input longint x0, input longint y0,
                                                output longint mag);
    longint x;
    longint y;
    longint acc;
    longint xs;
    longint ys;
    x = x0;
    y = y0;
    acc = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (y >= 0) begin
        x = x + xs;
        y = y - ys;
        acc = acc + longint'(AtanTurns[i]);
      end else begin
        x = x - xs;
        y = y + ys;
        acc = acc - longint'(AtanTurns[i]);
      end
    end
    mag = x;
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
    return acc[30:0];
  endfunction

  // Multiplies by the CORDIC gain in Q30, split so that nothing overflows.
  function automatic longint gain_scale(input longint v);
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] ph;
    logic [63:0] pl;
    hi = 64'(v) >> 28;
    lo = 64'(v) & ((64'd1 << 28) - 1);
    ph = hi * 64'(GainQ30);
    pl = lo * 64'(GainQ30);
    return longint'((ph >> 2) + ((((ph & 64'd3) << 28) + pl) >> 30));
  endfunction

  // Rounds half up from 2^-32 turn to angle units; a full turn wraps to zero.
  function automatic logic [AngleBits-1:0] units_of(input logic [31:0] t);
    logic [32:0] sum;
    sum = {1'b0, t} + (33'd1 << (31 - AngleBits));
    return sum[32 - AngleBits +: AngleBits];
  endfunction

  // Expected azimuth and elevation of one point around the current centre.
  function automatic angles_t predict_angles(input point_t p);
    angles_t r;
    longint dx;
    longint dy;
    longint dz;
    longint ax;
    longint ay;
    longint az;
    longint m;
    longint hk;
    longint dummy;
    logic [30:0] a;
    logic [31:0] t;
    logic [AngleBits-1:0] elev;
    int s;
    dx = longint'(p.point_x) - longint'(centre_x);
    dy = longint'(p.point_y) - longint'(centre_y);
    dz = longint'(p.point_z) - longint'(centre_z);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    r = '0;
    elev = '0;
    m = ax;
    if (ay > m) m = ay;
    if (az > m) m = az;
    if (m == 0) return r;
    s = 0;
    while (m < (longint'(1) << NormTop)) begin
      m = m << 1;
      s++;
    end
    ax = ax << s;
    ay = ay << s;
    az = az << s;
    if (ax == 0 && az == 0) begin
      elev = QuarterUnits;
    end else begin
      if (az == 0) a = '0;
      else if (ax == 0) a = QuarterTurn;
      else a = cordic_vector(ax, az, dummy);
      // Map the first-quadrant angle to the quadrant of (dx, dz).
      if (dx >= 0 && dz >= 0) t = {1'b0, a};
      else if (dx < 0 && dz >= 0) t = HalfTurn - {1'b0, a};
      else if (dx < 0) t = HalfTurn + {1'b0, a};
      else t = 32'd0 - {1'b0, a};
      r.azimuth = units_of(t);
      if (ay != 0) begin
        a = cordic_vector(ax, az, hk);
        elev = units_of({1'b0, cordic_vector(hk, gain_scale(ay), dummy)});
      end
    end
    if (dy < 0) elev = -elev;
    r.elevation = elev;
    return r;
  endfunction

  function automatic int draw_wait(input int limit);
    return (limit == 0) ? 0 : int'($urandom_range(0, limit));
  endfunction

  // Sender: presents queued points, with a random gap after each one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_cnt    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        angles_queue.push_back(predict_angles(in_data_i));
        points_sent <= points_sent + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_cnt > 0) begin
          gap_cnt    <= gap_cnt - 1;
          in_valid_i <= 1'b0;
        end else if (point_queue.size() > 0) begin
          in_data_i  <= point_queue.pop_front();
          in_valid_i <= 1'b1;
          gap_cnt    <= draw_wait(max_gap);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction and stalls at random after it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cnt   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (angles_queue.size() == 0) begin
          $display("%0t: unexpected result az=%0d el=%0d", $time,
                   out_data_o.azimuth, out_data_o.elevation);
          error_cnt++;
        end else begin
          automatic angles_t exp_a = angles_queue.pop_front();
          if (exp_a.azimuth !== out_data_o.azimuth) begin
            $display("%0t: azimuth mismatch expected %0d actual %0d", $time,
                     exp_a.azimuth, out_data_o.azimuth);
            error_cnt++;
          end
          if (exp_a.elevation !== out_data_o.elevation) begin
            $display("%0t: elevation mismatch expected %0d actual %0d", $time,
                     exp_a.elevation, out_data_o.elevation);
            error_cnt++;
          end
        end
        angles_checked++;
      end
      if (stall_cnt > 0) begin
        stall_cnt   <= stall_cnt - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i) stall_cnt <= draw_wait(max_stall);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, angles_queue.size());
      $display("** sphere_point_to_angles_unit: FAILED **");
      $finish;
    end
  end

  task automatic write_centre(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegCenterX: centre_x = value;
      RegCenterY: centre_y = value;
      default:    centre_z = value;
    endcase
  endtask

  task automatic set_centre(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    write_centre(RegCenterX, x);
    write_centre(RegCenterY, y);
    write_centre(RegCenterZ, z);
  endtask

  task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    point_queue.push_back(p);
  endtask

  // One coordinate: full range, small, near the centre, at the centre, an extreme or a scaled offset.
  function automatic logic [31:0] rand_coord(input logic [31:0] c);
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3:       return 32'($signed($urandom_range(0, 4096)) - 2048);
      4:       return c + 32'($signed($urandom_range(0, 64)) - 32);
      5:       return c;
      6:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return c + ($urandom >> $urandom_range(0, 31));
    endcase
  endfunction

  task automatic add_random_points(input int n);
    for (int k = 0; k < n; k++) begin
      add_point(rand_coord(centre_x), rand_coord(centre_y), rand_coord(centre_z));
    end
  endtask

  // Lets every queued point through and every result come back.
  task automatic drain;
    do @(posedge clk_i);
    while (point_queue.size() > 0 || in_valid_i || angles_queue.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    centre_x = '0;
    centre_y = '0;
    centre_z = '0;
    points_sent = 0;
    angles_checked = 0;
    error_cnt = 0;
    cycle_cnt = 0;
    max_gap = 12;
    max_stall = 12;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points around the reset centre: zero offset, axes, quadrants, extremes.
    add_point(0, 0, 0);
    add_point(32'h0001_0000, 0, 0);
    add_point(32'hffff_0000, 0, 0);
    add_point(0, 0, 32'h0001_0000);
    add_point(0, 0, 32'hffff_0000);
    add_point(0, 32'h0000_0001, 0);
    add_point(0, 32'hffff_ffff, 0);
    add_point(32'h0000_0005, 32'h0000_0005, 32'h0000_0005);
    add_point(32'hffff_fffb, 32'hffff_fff0, 32'h0000_0007);
    add_point(32'hffff_fff9, 32'h0000_0003, 32'hffff_fff9);
    add_point(32'h0000_0009, 32'hffff_fffd, 32'hffff_fff1);
    add_point(32'h0003_0000, 0, 32'h0004_0000);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    add_point(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0000);
    add_point(32'h8000_0000, 0, 32'h7fff_ffff);
    drain();

    // Centre at the extremes so that the offsets use all 33 bits.
    set_centre(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_random_points(RandomPoints);
    drain();

    set_centre(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_random_points(RandomPoints);
    drain();

    // Back-to-back stretch without idling on either side.
    max_gap = 0;
    max_stall = 0;
    set_centre(0, 0, 0);
    add_random_points(RandomPoints);
    drain();

    // Random centres with mixed idling.
    for (int ph = 0; ph < 4; ph++) begin
      max_gap = (ph == 1) ? 0 : 12;
      max_stall = (ph == 2) ? 0 : 12;
      set_centre($urandom, $urandom, $urandom);
      add_random_points(RandomPoints);
      drain();
    end

    $display("Checked %0d results for %0d points over eight centre settings,", angles_checked,
             points_sent);
    $display("including zero offsets, axis points and full-range offsets.");
    if (error_cnt == 0) begin
      $display("** sphere_point_to_angles_unit: PASSED **");
    end else begin
      $display("** sphere_point_to_angles_unit: FAILED **");
    end
    $finish;
  end

endmodule
